/* rtl/tsvt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tsvt_pkg - shared types and constants of the tagged summed-volume table
// Register indexes, fixed field widths and the sequencer state encoding.
// ----------------------------------------------------------------------------
package tsvt_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int VOXEL_W    = 8;
    localparam int TAG_IDX_W  = 2;
    localparam int COORD_W    = 4;
    localparam int SIZE_W     = 5;
    localparam int COUNT_W    = 13;
    localparam int TAG_REGS   = 4;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TAG_0  = 3'd0,
        REG_TAG_1  = 3'd1,
        REG_TAG_2  = 3'd2,
        REG_TAG_3  = 3'd3,
        REG_SIZE_X = 3'd4,
        REG_SIZE_Y = 3'd5,
        REG_SIZE_Z = 3'd6
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RUN   = 4'b0010,
        S_WRITE = 4'b0100,
        S_FIN   = 4'b1000
    } t_state;

    typedef enum logic [1:0] {
        K_NONE  = 2'd0,
        K_READ  = 2'd1,
        K_MATCH = 2'd2
    } t_kind;

    typedef logic [COORD_W-1:0] t_coord;

endpackage
`default_nettype wire

/* rtl/tagged_summed_volume_table.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tagged_summed_volume_table - 3D summed-volume table per tag byte
// Builds prefix counts of matching voxels and answers box-count queries.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall): a word with i_mode 0 loads one voxel in
// z, y, x raster order; i_mode 1 queries the count of voxels equal to a tag
// inside an inclusive box. Output channel (o_valid / i_stall) carries one word
// per query: o_count and o_error. Loads produce no output word.
// Configuration channel (i_cfg_valid / o_cfg_ready): tag bytes and sizes,
// written while the block is idle and no input word is offered; a write to
// any index from 0 to 6 restarts loading.
// One single-port-read table memory and one add/subtract accumulator are
// shared by a corner sequencer with at most one read per cycle.
// A load holds o_stall while, per tag slot, the sequencer runs and one write
// follows. A query runs the sequencer, then S_FIN fills the output register;
// a rejected query goes straight to S_FIN. Next word is taken once idle.
// Reset clears control state, tags to zero and sizes to 16; the table itself
// is not cleared, since every entry is written by loading before it is read.
// A stalled result holds in the output register; a finished query waits for
// it to drain while a new word is not taken.
// ----------------------------------------------------------------------------
module tagged_summed_volume_table #(
    parameter int NUM_TAGS  = 4,
    parameter int MAX_DIM_X = 16,
    parameter int MAX_DIM_Y = 16,
    parameter int MAX_DIM_Z = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic                            i_mode,
    input  wire logic [tsvt_pkg::VOXEL_W-1:0]    i_voxel,
    input  wire logic [tsvt_pkg::TAG_IDX_W-1:0]  i_tag_index,
    input  wire tsvt_pkg::t_coord                i_z_low,
    input  wire tsvt_pkg::t_coord                i_y_low,
    input  wire tsvt_pkg::t_coord                i_x_low,
    input  wire tsvt_pkg::t_coord                i_z_high,
    input  wire tsvt_pkg::t_coord                i_y_high,
    input  wire tsvt_pkg::t_coord                i_x_high,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [tsvt_pkg::COUNT_W-1:0]         o_count,
    output logic                                 o_error,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [tsvt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [tsvt_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tsvt_pkg::*;

    localparam int PLANE  = MAX_DIM_Y * MAX_DIM_X;
    localparam int VOLUME = MAX_DIM_Z * PLANE;
    localparam int DEPTH  = NUM_TAGS * VOLUME;
    localparam int AW     = $clog2(DEPTH);
    localparam int TW     = (NUM_TAGS > 1) ? $clog2(NUM_TAGS) : 1;
    localparam int CX     = $clog2(MAX_DIM_X);
    localparam int CY     = $clog2(MAX_DIM_Y);
    localparam int CZ     = $clog2(MAX_DIM_Z);
    localparam int PX     = $clog2(MAX_DIM_X + 1);
    localparam int PY     = $clog2(MAX_DIM_Y + 1);
    localparam int PZ     = $clog2(MAX_DIM_Z + 1);

    logic [COUNT_W-1:0] mem [DEPTH];

    t_state                r_state, n_state;
    logic [3:0]            r_step, n_step;
    logic                  r_is_load, n_is_load;
    logic [TW-1:0]         r_slot, n_slot;
    logic [VOXEL_W-1:0]    r_voxel, n_voxel;
    logic [PZ-1:0]         r_a_z, n_a_z, r_b_z, n_b_z;
    logic [PY-1:0]         r_a_y, n_a_y, r_b_y, n_b_y;
    logic [PX-1:0]         r_a_x, n_a_x, r_b_x, n_b_x;
    logic [COUNT_W-1:0]    r_acc, n_acc;
    logic                  r_err, n_err;
    t_kind                 r_p_kind, n_p_kind;
    logic                  r_p_sub, n_p_sub;
    logic                  r_p_match, n_p_match;
    logic [COUNT_W-1:0]    r_rd_data;
    logic [CZ-1:0]         r_ld_z, n_ld_z;
    logic [CY-1:0]         r_ld_y, n_ld_y;
    logic [CX-1:0]         r_ld_x, n_ld_x;
    logic                  r_loaded, n_loaded;
    logic [VOXEL_W-1:0]    r_tags [TAG_REGS];
    logic [SIZE_W-1:0]     r_size_x, r_size_y, r_size_z;
    logic                  r_out_valid, n_out_valid;
    logic [COUNT_W-1:0]    r_out_count, n_out_count;
    logic                  r_out_error, n_out_error;

    logic [SIZE_W-1:0]     eff_x, eff_y, eff_z;
    logic                  in_acc, out_acc, cfg_acc;
    logic                  q_err;
    logic [2:0]            slot3;
    logic [VOXEL_W-1:0]    slot_tag;
    logic [PZ-1:0]         cz1, ad_z1;
    logic [PY-1:0]         cy1, ad_y1;
    logic [PX-1:0]         cx1, ad_x1;
    logic                  c_zero;
    t_kind                 c_kind;
    logic [31:0]           addr32;
    logic [AW-1:0]         addr;
    logic                  mem_re, mem_we;
    logic [COUNT_W-1:0]    term;

    assign in_acc      = i_valid && !o_stall;
    assign out_acc     = r_out_valid && !i_stall;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !i_valid;
    assign o_valid     = r_out_valid;
    assign o_count     = r_out_count;
    assign o_error     = r_out_error;

    always_comb begin
        if (r_size_x == '0) begin
            eff_x = SIZE_W'(1);
        end else if (32'(r_size_x) > MAX_DIM_X) begin
            eff_x = SIZE_W'(MAX_DIM_X);
        end else begin
            eff_x = r_size_x;
        end
        if (r_size_y == '0) begin
            eff_y = SIZE_W'(1);
        end else if (32'(r_size_y) > MAX_DIM_Y) begin
            eff_y = SIZE_W'(MAX_DIM_Y);
        end else begin
            eff_y = r_size_y;
        end
        if (r_size_z == '0) begin
            eff_z = SIZE_W'(1);
        end else if (32'(r_size_z) > MAX_DIM_Z) begin
            eff_z = SIZE_W'(MAX_DIM_Z);
        end else begin
            eff_z = r_size_z;
        end
    end

    assign q_err = !r_loaded || (32'(i_tag_index) >= NUM_TAGS)
                || (i_z_low > i_z_high) || (i_y_low > i_y_high) || (i_x_low > i_x_high)
                || (SIZE_W'(i_z_high) >= eff_z) || (SIZE_W'(i_y_high) >= eff_y)
                || (SIZE_W'(i_x_high) >= eff_x);

    assign slot3    = 3'(r_slot);
    assign slot_tag = (32'(slot3) < TAG_REGS) ? r_tags[slot3[1:0]] : '0;

    // corner select: a set bit picks the a side of that axis
    assign cz1    = r_step[2] ? r_a_z : r_b_z;
    assign cy1    = r_step[1] ? r_a_y : r_b_y;
    assign cx1    = r_step[0] ? r_a_x : r_b_x;
    assign c_zero = (cz1 == '0) || (cy1 == '0) || (cx1 == '0);

    always_comb begin
        if (r_step[3]) begin
            c_kind = K_NONE;
        end else if (r_is_load && (r_step[2:0] == 3'd0)) begin
            c_kind = K_MATCH;
        end else if (c_zero) begin
            c_kind = K_NONE;
        end else begin
            c_kind = K_READ;
        end
    end

    assign ad_z1  = (r_state == S_WRITE) ? r_b_z : cz1;
    assign ad_y1  = (r_state == S_WRITE) ? r_b_y : cy1;
    assign ad_x1  = (r_state == S_WRITE) ? r_b_x : cx1;
    assign addr32 = 32'(r_slot) * 32'(VOLUME)
                  + (32'(ad_z1) - 32'd1) * 32'(PLANE)
                  + (32'(ad_y1) - 32'd1) * 32'(MAX_DIM_X)
                  + 32'(ad_x1) - 32'd1;
    assign addr   = addr32[AW-1:0];
    assign mem_re = (r_state == S_RUN) && (c_kind == K_READ);
    assign mem_we = (r_state == S_WRITE);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[addr] <= r_acc;
        end
        if (mem_re) begin
            r_rd_data <= mem[addr];
        end
    end

    always_comb begin
        unique case (r_p_kind)
            K_READ:  term = r_rd_data;
            K_MATCH: term = COUNT_W'(r_p_match);
            default: term = '0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_is_load   = r_is_load;
        n_slot      = r_slot;
        n_voxel     = r_voxel;
        n_a_z       = r_a_z;
        n_a_y       = r_a_y;
        n_a_x       = r_a_x;
        n_b_z       = r_b_z;
        n_b_y       = r_b_y;
        n_b_x       = r_b_x;
        n_acc       = r_acc;
        n_err       = r_err;
        n_p_kind    = r_p_kind;
        n_p_sub     = r_p_sub;
        n_p_match   = r_p_match;
        n_ld_z      = r_ld_z;
        n_ld_y      = r_ld_y;
        n_ld_x      = r_ld_x;
        n_loaded    = r_loaded;
        n_out_valid = r_out_valid;
        n_out_count = r_out_count;
        n_out_error = r_out_error;

        if (out_acc) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_step    = '0;
                    n_acc     = '0;
                    n_err     = 1'b0;
                    n_p_kind  = K_NONE;
                    n_voxel   = i_voxel;
                    n_is_load = !i_mode;
                    if (!i_mode) begin
                        n_slot  = '0;
                        n_a_z   = PZ'(r_ld_z);
                        n_a_y   = PY'(r_ld_y);
                        n_a_x   = PX'(r_ld_x);
                        n_b_z   = PZ'(r_ld_z) + PZ'(1);
                        n_b_y   = PY'(r_ld_y) + PY'(1);
                        n_b_x   = PX'(r_ld_x) + PX'(1);
                        n_state = S_RUN;
                    end else if (q_err) begin
                        n_err   = 1'b1;
                        n_state = S_FIN;
                    end else begin
                        n_slot  = TW'(i_tag_index);
                        n_a_z   = PZ'(i_z_low);
                        n_a_y   = PY'(i_y_low);
                        n_a_x   = PX'(i_x_low);
                        n_b_z   = PZ'(i_z_high) + PZ'(1);
                        n_b_y   = PY'(i_y_high) + PY'(1);
                        n_b_x   = PX'(i_x_high) + PX'(1);
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                n_acc     = r_p_sub ? r_acc - term : r_acc + term;
                n_p_kind  = c_kind;
                n_p_sub   = (^r_step[2:0]) ^ r_is_load;
                n_p_match = (r_voxel == slot_tag);
                if (c_kind == K_MATCH) begin
                    n_p_sub = 1'b0;
                end
                if (r_step[3]) begin
                    n_state = r_is_load ? S_WRITE : S_FIN;
                end else begin
                    n_step = r_step + 4'd1;
                end
            end
            S_WRITE: begin
                if (32'(r_slot) == NUM_TAGS - 1) begin
                    n_state = S_IDLE;
                    if (32'(r_ld_x) + 32'd1 < 32'(eff_x)) begin
                        n_ld_x = r_ld_x + CX'(1);
                    end else begin
                        n_ld_x = '0;
                        if (32'(r_ld_y) + 32'd1 < 32'(eff_y)) begin
                            n_ld_y = r_ld_y + CY'(1);
                        end else begin
                            n_ld_y = '0;
                            if (32'(r_ld_z) + 32'd1 < 32'(eff_z)) begin
                                n_ld_z = r_ld_z + CZ'(1);
                            end else begin
                                n_ld_z   = '0;
                                n_loaded = 1'b1;
                            end
                        end
                    end
                end else begin
                    n_slot   = r_slot + TW'(1);
                    n_step   = '0;
                    n_acc    = '0;
                    n_p_kind = K_NONE;
                    n_state  = S_RUN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out_count = r_err ? '0 : r_acc;
                    n_out_error = r_err;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (cfg_acc && (32'(i_cfg_index) <= 32'(REG_SIZE_Z))) begin
            n_ld_z   = '0;
            n_ld_y   = '0;
            n_ld_x   = '0;
            n_loaded = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_p_kind    <= K_NONE;
            r_ld_z      <= '0;
            r_ld_y      <= '0;
            r_ld_x      <= '0;
            r_loaded    <= 1'b0;
            r_out_valid <= 1'b0;
            r_size_x    <= SIZE_RESET;
            r_size_y    <= SIZE_RESET;
            r_size_z    <= SIZE_RESET;
            for (int i = 0; i < TAG_REGS; i++) begin
                r_tags[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_p_kind    <= n_p_kind;
            r_ld_z      <= n_ld_z;
            r_ld_y      <= n_ld_y;
            r_ld_x      <= n_ld_x;
            r_loaded    <= n_loaded;
            r_out_valid <= n_out_valid;
            if (cfg_acc) begin
                unique case (i_cfg_index)
                    REG_TAG_0, REG_TAG_1, REG_TAG_2, REG_TAG_3: begin
                        if (32'(i_cfg_index) < NUM_TAGS) begin
                            r_tags[i_cfg_index[1:0]] <= i_cfg_data;
                        end
                    end
                    REG_SIZE_X: r_size_x <= i_cfg_data[SIZE_W-1:0];
                    REG_SIZE_Y: r_size_y <= i_cfg_data[SIZE_W-1:0];
                    REG_SIZE_Z: r_size_z <= i_cfg_data[SIZE_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_load   <= n_is_load;
        r_slot      <= n_slot;
        r_voxel     <= n_voxel;
        r_a_z       <= n_a_z;
        r_a_y       <= n_a_y;
        r_a_x       <= n_a_x;
        r_b_z       <= n_b_z;
        r_b_y       <= n_b_y;
        r_b_x       <= n_b_x;
        r_acc       <= n_acc;
        r_err       <= n_err;
        r_p_sub     <= n_p_sub;
        r_p_match   <= n_p_match;
        r_out_count <= n_out_count;
        r_out_error <= n_out_error;
    end

endmodule
`default_nettype wire
